@@ hw/rtl/bgcd_pkg.sv @@
package bgcd_pkg;

   localparam int MAX_DIGITS    = 256;
   localparam int GROUP_DIGITS  = 16;
   localparam int RESULT_LIMIT  = 16;
   localparam int LENGTH_CAP    = 511;

   localparam int CNT_W       = $clog2(MAX_DIGITS);
   localparam int LEN_W       = $clog2(MAX_DIGITS + 1);
   // 10^n < 2^(4n), so the count of common twos stays below 4 * MAX_DIGITS
   localparam int TWOS_W      = $clog2(4 * MAX_DIGITS + 1);
   localparam int EMIT_GROUPS = (MAX_DIGITS + GROUP_DIGITS - 1) / GROUP_DIGITS;
   localparam int EMIT_DIGITS = EMIT_GROUPS * GROUP_DIGITS;
   localparam int POS_W       = (EMIT_DIGITS > 1) ? $clog2(EMIT_DIGITS) : 1;
   localparam int GCNT_W      = (GROUP_DIGITS > 1) ? $clog2(GROUP_DIGITS) : 1;
   localparam int CMP_W       =
      $clog2(EMIT_DIGITS + MAX_DIGITS + RESULT_LIMIT * GROUP_DIGITS + LENGTH_CAP + 1) + 1;

   typedef logic [3:0] digit_type;
   typedef logic [2:0] op_type;

   typedef struct packed {
      digit_type a;
      digit_type b;
   } pair_type;

   typedef struct packed {
      logic clear;
      logic en_a;
      logic en_b;
      logic up;
   } cell_ctl_type;

   typedef struct packed {
      op_type op;
      logic   first;
      logic   step;
   } alu_ctl_type;

   localparam op_type OP_SCAN    = 3'd0;
   localparam op_type OP_HALF_AB = 3'd1;
   localparam op_type OP_HALF_A  = 3'd2;
   localparam op_type OP_HALF_B  = 3'd3;
   localparam op_type OP_SUB_AB  = 3'd4;
   localparam op_type OP_SUB_BA  = 3'd5;
   localparam op_type OP_DBL_A   = 3'd6;
   localparam op_type OP_DBL_B   = 3'd7;

endpackage

@@ hw/rtl/bgcd_cell.sv @@
module bgcd_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  bgcd_pkg::cell_ctl_type ctl,
   input  bgcd_pkg::pair_type    lo,
   input  bgcd_pkg::pair_type    hi,
   output bgcd_pkg::pair_type    q
);
   import bgcd_pkg::*;

   pair_type q_ff, q_in;

   always_comb begin
      q_in = q_ff;
      if (ctl.clear) begin
         q_in = '0;
      end else begin
         if (ctl.en_a) begin
            q_in.a = ctl.up ? lo.a : hi.a;
         end
         if (ctl.en_b) begin
            q_in.b = ctl.up ? lo.b : hi.b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

@@ hw/rtl/bgcd_digit_alu.sv @@
module bgcd_digit_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  bgcd_pkg::alu_ctl_type ctl,
   input  bgcd_pkg::pair_type   din,
   output bgcd_pkg::pair_type   dout
);
   import bgcd_pkg::*;

   typedef struct packed {
      logic      c;
      digit_type d;
   } step_type;

   function automatic step_type halve(input digit_type x, input logic r);
      logic [4:0] v;
      step_type   s;
      v   = {1'b0, x} + (r ? 5'd10 : 5'd0);
      s.d = v[4:1];
      s.c = v[0];
      return s;
   endfunction

   function automatic step_type subd(input digit_type x, input digit_type y, input logic c);
      logic [4:0] t;
      step_type   s;
      t = {1'b0, x} + 5'd10 - {1'b0, y} - {4'd0, c};
      if (t >= 5'd10) begin
         s.d = 4'(t - 5'd10);
         s.c = 1'b0;
      end else begin
         s.d = t[3:0];
         s.c = 1'b1;
      end
      return s;
   endfunction

   function automatic step_type dbl(input digit_type x, input logic c);
      logic [4:0] v;
      step_type   s;
      v = {x, 1'b0} + {4'd0, c};
      if (v >= 5'd10) begin
         s.d = 4'(v - 5'd10);
         s.c = 1'b1;
      end else begin
         s.d = v[3:0];
         s.c = 1'b0;
      end
      return s;
   endfunction

   logic     cy_a_ff, cy_a_in, cy_b_ff, cy_b_in;
   logic     ca, cb;
   step_type sa, sb;

   assign ca = ctl.first ? 1'b0 : cy_a_ff;
   assign cb = ctl.first ? 1'b0 : cy_b_ff;

   always_comb begin
      dout    = din;
      cy_a_in = 1'b0;
      cy_b_in = 1'b0;
      sa      = '0;
      sb      = '0;
      unique case (ctl.op)
         OP_SCAN: begin
            dout = din;
         end
         OP_HALF_AB: begin
            sa      = halve(din.a, ca);
            sb      = halve(din.b, cb);
            dout.a  = sa.d;
            dout.b  = sb.d;
            cy_a_in = sa.c;
            cy_b_in = sb.c;
         end
         OP_HALF_A: begin
            sa      = halve(din.a, ca);
            dout.a  = sa.d;
            cy_a_in = sa.c;
         end
         OP_HALF_B: begin
            sb      = halve(din.b, cb);
            dout.b  = sb.d;
            cy_b_in = sb.c;
         end
         OP_SUB_AB: begin
            sa      = subd(din.a, din.b, ca);
            dout.a  = sa.d;
            cy_a_in = sa.c;
         end
         OP_SUB_BA: begin
            sb      = subd(din.b, din.a, cb);
            dout.b  = sb.d;
            cy_b_in = sb.c;
         end
         OP_DBL_A: begin
            sa      = dbl(din.a, ca);
            dout.a  = sa.d;
            cy_a_in = sa.c;
         end
         OP_DBL_B: begin
            sb      = dbl(din.b, cb);
            dout.b  = sb.d;
            cy_b_in = sb.c;
         end
         default: begin
            dout = din;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cy_a_ff <= 1'b0;
         cy_b_ff <= 1'b0;
      end else if (ctl.step) begin
         cy_a_ff <= cy_a_in;
         cy_b_ff <= cy_b_in;
      end
   end

endmodule

@@ hw/rtl/bcd_binary_gcd.sv @@
// Decimal gcd engine (Stein's binary method) over two BCD operands.
// Input channel req_*: one decimal digit per beat, most significant first;
// req_operand_select picks the operand, req_last_digit on a second-operand
// beat closes the input and starts the computation. Digits above nine count
// as nine; digits past the store depth are dropped and flagged.
// Result channel rsp_*: the gcd as packed groups of BCD digits, most
// significant group first, rsp_group_last on the final group.
// Digits load at one beat per cycle. The computation walks a ring of digit
// cells through one serial digit unit in halving, subtraction, scan and
// doubling passes; a gcd needs up to about 7 passes per operand digit plus
// one per common factor of two, plus a final length scan. req_stall stays
// high from the start beat to the final result beat. When rsp_stall holds
// the result register, digit shifting pauses at the next complete group.
// Reset clears all cells, the state, the pass, digit and twos counts, the
// overflow flag and rsp_valid; scan flags and result data are not reset.
module bcd_binary_gcd (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operand_select,
   input  logic [3:0]  req_digit_value,
   input  logic        req_last_digit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digit_group,
   output logic [8:0]  rsp_result_length,
   output logic        rsp_overflow_flag,
   output logic        rsp_group_last
);
   import bgcd_pkg::*;

   localparam logic [1:0] S_LOAD   = 2'd0;
   localparam logic [1:0] S_PASS   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   localparam logic [1:0] PH_INIT  = 2'd0;
   localparam logic [1:0] PH_LOOP  = 2'd1;
   localparam logic [1:0] PH_DBL   = 2'd2;
   localparam logic [1:0] PH_FINAL = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        ph_ff, ph_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TWOS_W-1:0] twos_ff, twos_in;
   logic              res_sel_ff, res_sel_in;
   logic              nza_ff, nza_in, nzb_ff, nzb_in;
   logic              para_ff, para_in, parb_ff, parb_in;
   logic              ge_ff, ge_in, done_ff, done_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  first_len_ff, first_len_in, second_len_ff, second_len_in;
   logic              ovf_ff, ovf_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [GCNT_W-1:0] gcnt_ff, gcnt_in;
   logic              incl_ff, incl_in;
   logic [63:0]       grp_ff, grp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_group_ff, rsp_group_in;
   logic [8:0]        rsp_len_ff, rsp_len_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_last_ff, rsp_last_in;

   pair_type     cell_q [MAX_DIGITS];
   pair_type     edge_lo, alu_in, alu_out;
   cell_ctl_type cell_ctl;
   alu_ctl_type  alu_ctl;

   logic             accept, msb_pass, pass_end;
   logic [CNT_W-1:0] idx;
   digit_type        dsat, rd, emit_digit;
   logic [LEN_W-1:0] len_base;
   logic             ge_prev, done_prev;
   logic             start_grp, incl, complete, out_busy, adv, finish, pos_lt_n;
   logic [8:0]       len_sat;

   assign req_stall = (state_ff != S_LOAD);
   assign accept    = req_valid && !req_stall;
   assign dsat      = (req_digit_value > 4'd9) ? 4'd9 : req_digit_value;
   assign msb_pass  = (op_ff == OP_HALF_AB) || (op_ff == OP_HALF_A) || (op_ff == OP_HALF_B);
   assign pass_end  = (cnt_ff == CNT_W'(MAX_DIGITS - 1));
   assign idx       = msb_pass ? (CNT_W'(MAX_DIGITS - 1) - cnt_ff) : cnt_ff;

   // serial unit reads the ring at the end it is walking from
   assign alu_in        = msb_pass ? cell_q[MAX_DIGITS-1] : cell_q[0];
   assign alu_ctl.op    = op_ff;
   assign alu_ctl.first = (cnt_ff == '0);
   assign alu_ctl.step  = (state_ff == S_PASS);

   bgcd_digit_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .din   (alu_in),
      .dout  (alu_out)
   );

   always_comb begin
      priority if (state_ff == S_LOAD) begin
         edge_lo = '{a: dsat, b: dsat};
      end else if (state_ff == S_EMIT) begin
         edge_lo = cell_q[MAX_DIGITS-1];
      end else begin
         edge_lo = alu_out;
      end
   end

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      pair_type lo, hi;
      if (i == 0) begin : g_first
         assign lo = edge_lo;
      end else begin : g_mid_lo
         assign lo = cell_q[i-1];
      end
      if (i == MAX_DIGITS - 1) begin : g_last
         assign hi = alu_out;
      end else begin : g_mid_hi
         assign hi = cell_q[i+1];
      end
      bgcd_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (cell_ctl),
         .lo    (lo),
         .hi    (hi),
         .q     (cell_q[i])
      );
   end

   // output side
   assign pos_lt_n   = (CMP_W'(pos_ff) < CMP_W'(MAX_DIGITS));
   assign rd         = res_sel_ff ? cell_q[MAX_DIGITS-1].b : cell_q[MAX_DIGITS-1].a;
   assign emit_digit = pos_lt_n ? rd : 4'd0;
   // a group joins the output once it holds a significant digit and fits the limit
   assign start_grp  = (gcnt_ff == GCNT_W'(GROUP_DIGITS - 1))
                       && (CMP_W'(pos_ff) < CMP_W'(RESULT_LIMIT * GROUP_DIGITS))
                       && (CMP_W'(pos_ff) < CMP_W'(len_ff) + CMP_W'(GROUP_DIGITS - 1));
   assign incl       = incl_ff || start_grp;
   assign complete   = incl && (gcnt_ff == '0);
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign adv        = !(complete && out_busy);
   assign finish     = (pos_ff == '0);
   assign len_sat    = (CMP_W'(len_ff) > CMP_W'(LENGTH_CAP)) ? 9'(LENGTH_CAP) : 9'(len_ff);

   always_comb begin
      state_in      = state_ff;
      ph_in         = ph_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      twos_in       = twos_ff;
      res_sel_in    = res_sel_ff;
      nza_in        = nza_ff;
      nzb_in        = nzb_ff;
      para_in       = para_ff;
      parb_in       = parb_ff;
      ge_in         = ge_ff;
      done_in       = done_ff;
      len_in        = len_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      ovf_in        = ovf_ff;
      pos_in        = pos_ff;
      gcnt_in       = gcnt_ff;
      incl_in       = incl_ff;
      grp_in        = grp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_group_in  = rsp_group_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      cell_ctl      = '0;
      ge_prev       = 1'b1;
      done_prev     = 1'b0;
      len_base      = LEN_W'(1);

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               cell_ctl.up = 1'b1;
               if (!req_operand_select) begin
                  if (first_len_ff < LEN_W'(MAX_DIGITS)) begin
                     cell_ctl.en_a = 1'b1;
                     first_len_in  = first_len_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  if (second_len_ff < LEN_W'(MAX_DIGITS)) begin
                     cell_ctl.en_b = 1'b1;
                     second_len_in = second_len_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_last_digit) begin
                     state_in = S_PASS;
                     ph_in    = PH_INIT;
                     op_in    = OP_SCAN;
                     cnt_in   = '0;
                     twos_in  = '0;
                  end
               end
            end
         end

         S_PASS: begin
            cell_ctl.en_a = 1'b1;
            cell_ctl.en_b = 1'b1;
            cell_ctl.up   = msb_pass;
            if (cnt_ff != '0) begin
               ge_prev   = ge_ff;
               done_prev = done_ff;
               len_base  = len_ff;
            end
            nza_in = ((cnt_ff != '0) && nza_ff) || (alu_out.a != 4'd0);
            nzb_in = ((cnt_ff != '0) && nzb_ff) || (alu_out.b != 4'd0);
            if (idx == '0) begin
               para_in = alu_out.a[0];
               parb_in = alu_out.b[0];
            end
            // lsb-first: the highest differing digit is the latest one
            if (msb_pass) begin
               ge_in   = (!done_prev && (alu_out.a != alu_out.b))
                         ? (alu_out.a > alu_out.b) : ge_prev;
               done_in = done_prev || (alu_out.a != alu_out.b);
            end else begin
               ge_in   = (alu_out.a != alu_out.b) ? (alu_out.a > alu_out.b) : ge_prev;
               done_in = 1'b0;
            end
            len_in = len_base;
            if ((res_sel_ff ? alu_out.b : alu_out.a) != 4'd0) begin
               len_in = LEN_W'(idx) + LEN_W'(1);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (pass_end) begin
               cnt_in   = '0;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            state_in = S_PASS;
            unique case (ph_ff)
               PH_INIT, PH_LOOP: begin
                  if (!nza_ff || !nzb_ff) begin
                     if (ph_ff == PH_INIT) begin
                        // a zero operand gives zero
                        cell_ctl.clear = 1'b1;
                        res_sel_in     = 1'b0;
                        op_in          = OP_SCAN;
                        ph_in          = PH_FINAL;
                     end else begin
                        res_sel_in = !nza_ff;
                        if (twos_ff != '0) begin
                           op_in = (!nza_ff) ? OP_DBL_B : OP_DBL_A;
                           ph_in = PH_DBL;
                        end else begin
                           op_in = OP_SCAN;
                           ph_in = PH_FINAL;
                        end
                     end
                  end else begin
                     ph_in = PH_LOOP;
                     priority if (!para_ff && !parb_ff) begin
                        op_in   = OP_HALF_AB;
                        twos_in = twos_ff + TWOS_W'(1);
                     end else if (!para_ff) begin
                        op_in = OP_HALF_A;
                     end else if (!parb_ff) begin
                        op_in = OP_HALF_B;
                     end else if (ge_ff) begin
                        op_in = OP_SUB_AB;
                     end else begin
                        op_in = OP_SUB_BA;
                     end
                  end
               end
               PH_DBL: begin
                  twos_in = twos_ff - TWOS_W'(1);
                  if (twos_ff == TWOS_W'(1)) begin
                     op_in = OP_SCAN;
                     ph_in = PH_FINAL;
                  end
               end
               PH_FINAL: begin
                  state_in = S_EMIT;
                  pos_in   = POS_W'(EMIT_DIGITS - 1);
                  gcnt_in  = GCNT_W'(GROUP_DIGITS - 1);
                  incl_in  = 1'b0;
               end
               default: begin
                  state_in = S_LOAD;
               end
            endcase
         end

         S_EMIT: begin
            if (adv) begin
               if (pos_lt_n) begin
                  cell_ctl.en_a = 1'b1;
                  cell_ctl.en_b = 1'b1;
                  cell_ctl.up   = 1'b1;
               end
               grp_in  = ((gcnt_ff == GCNT_W'(GROUP_DIGITS - 1)) ? 64'd0 : (grp_ff << 4))
                         | {60'd0, emit_digit};
               incl_in = incl;
               pos_in  = pos_ff - POS_W'(1);
               gcnt_in = (gcnt_ff == '0) ? GCNT_W'(GROUP_DIGITS - 1)
                                         : (gcnt_ff - GCNT_W'(1));
               if (complete) begin
                  rsp_valid_in = 1'b1;
                  rsp_group_in = grp_in;
                  rsp_len_in   = len_sat;
                  rsp_ovf_in   = ovf_ff;
                  rsp_last_in  = finish;
               end
               if (finish) begin
                  state_in       = S_LOAD;
                  cell_ctl.clear = 1'b1;
                  first_len_in   = '0;
                  second_len_in  = '0;
                  twos_in        = '0;
                  ovf_in         = 1'b0;
                  res_sel_in     = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         ph_ff         <= PH_INIT;
         op_ff         <= OP_SCAN;
         cnt_ff        <= '0;
         twos_ff       <= '0;
         res_sel_ff    <= 1'b0;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
         incl_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ph_ff         <= ph_in;
         op_ff         <= op_in;
         cnt_ff        <= cnt_in;
         twos_ff       <= twos_in;
         res_sel_ff    <= res_sel_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_ff        <= ovf_in;
         incl_ff       <= incl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nza_ff       <= nza_in;
      nzb_ff       <= nzb_in;
      para_ff      <= para_in;
      parb_ff      <= parb_in;
      ge_ff        <= ge_in;
      done_ff      <= done_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      gcnt_ff      <= gcnt_in;
      grp_ff       <= grp_in;
      rsp_group_ff <= rsp_group_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digit_group   = rsp_group_ff;
   assign rsp_result_length = rsp_len_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;
   assign rsp_group_last    = rsp_last_ff;

   // a new result beat only comes out of the emit sequence
   a_beat_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result beat outside emit");

   // the twos count never survives into the next load
   a_twos_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (twos_ff == '0))
      else $error("twos count left over");

   // the start beat closes the input
   a_start_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operand_select && req_last_digit) |=> req_stall)
      else $error("input open during compute");

   // the final result beat of a gcd is always marked
   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && adv && finish) |=> (rsp_valid_ff && rsp_group_last))
      else $error("final group not marked");

endmodule
